// ===== src/ptr_pkg.sv =====
// Shared types, constants and helpers for the per-dimension trimmed range unit.
// No dependencies; every other file in src except ptr_stream_if uses this package.
`default_nettype none

package ptr_pkg;

  localparam int unsigned MAX_DIM_DEF  = 1024;
  localparam int unsigned MAX_KEEP_DEF = 16;

  localparam logic [31:0] F_LOWEST = 32'hFF7F_FFFF;
  localparam logic [31:0] F_MAX    = 32'h7F7F_FFFF;
  localparam logic [31:0] F_INF    = 32'h7F80_0000;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMENSIONS = 2'd0,
    CFG_KEEP_COUNT = 2'd1,
    CFG_TRUNC_MODE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] value;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  dim_index;
    logic [31:0] upper_bits;
    logic [31:0] lower_bits;
    logic        row_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input transaction and launch the row read
    logic load;    // write back the updated row and load the result register
  } ctl_cmd_t;

  // Maps float bits to an unsigned key in float order, with -0 equal to +0.
  function automatic logic [31:0] order_key(input logic [31:0] b);
    logic [31:0] x;
    x = ((b & 32'h7FFF_FFFF) == 32'd0) ? 32'd0 : b;
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

endpackage

`default_nettype wire

// ===== src/ptr_stream_if.sv =====
// Valid/ready channel carrying one payload of a given type.
// Depends on nothing; payload types come from ptr_pkg at instantiation.
`default_nettype none

interface ptr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/per_dimension_trimmed_range_unit.sv =====
// Top level of the per-dimension trimmed range unit: controller plus datapath.
// Depends on ptr_pkg, ptr_stream_if, ptr_ctrl and ptr_datapath.
//
// Each accepted element is handled in a read step and an update step: the
// first reads the dimension's row of kept largest and smallest values from
// the wide row memories, the second inserts the element into both rows with
// all entries compared in parallel and writes the rows back. The next element
// is accepted in the cycle after the write-back, so no new element is taken
// before the previous one is written back; a result that waits holds back
// only the write-back of the following element. Memories need no clearing
// pass: the first row of a data set initializes every dimension.
`default_nettype none

module per_dimension_trimmed_range_unit #(
  parameter int unsigned MAX_DIM  = ptr_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_KEEP = ptr_pkg::MAX_KEEP_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ptr_stream_if.sink                          in_if,
  ptr_stream_if.source                        out_if,
  input  wire logic                           cfg_we,
  input  wire logic [ptr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ptr_pkg::CFG_DATA_W-1:0] cfg_data
);

  ptr_pkg::ctl_cmd_t  cmd;
  ptr_pkg::out_item_t out_item;

  // Sequencing of transactions.
  ptr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // Storage and insert logic.
  ptr_datapath #(
    .MAX_DIM  (MAX_DIM),
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_item   (in_if.data),
    .out_item  (out_item)
  );

  assign out_if.data = out_item;

endmodule

`default_nettype wire

// ===== src/ptr_ctrl.sv =====
// Controller of the trimmed range unit: sequences accept, row update and result hand-off.
// Depends on ptr_pkg for the command struct.
`default_nettype none

module ptr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptr_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // The result register may be loaded once any waiting result has left.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.load   = (state_r == ST_CALC) && (!out_valid_r || out_ready);
  end

  // Next state and result-valid flag.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (cmd.load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A loaded result is presented in the following cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r) else $error("result not presented after load");

  // An accepted transaction always moves on to the update step.
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_CALC)) else $error("accept did not start update");

  // The update waits while an earlier result is still unread.
  a_calc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) && out_valid_r && !out_ready |=> (state_r == ST_CALC))
    else $error("update left while result blocked");

endmodule

`default_nettype wire

// ===== src/ptr_datapath.sv =====
// Datapath of the trimmed range unit: configuration, dimension counter, row memories
// and the parallel sorted insert. Depends on ptr_pkg.
`default_nettype none

module ptr_datapath #(
  parameter int unsigned MAX_DIM  = ptr_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_KEEP = ptr_pkg::MAX_KEEP_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ptr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire ptr_pkg::ctl_cmd_t                 cmd,
  input  wire ptr_pkg::in_item_t                 in_item,
  output ptr_pkg::out_item_t                     out_item
);

  localparam int unsigned DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned KW    = $clog2(MAX_KEEP + 1);
  localparam int unsigned ROW_W = MAX_KEEP * 32;

  // Configuration registers.
  logic [10:0] dims_cfg_r;
  logic [4:0]  keep_cfg_r;
  logic        trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_cfg_r <= 11'd1;
      keep_cfg_r <= 5'd0;
      trunc_r    <= 1'b0;
    end else if (cfg_we) begin
      case (ptr_pkg::cfg_idx_t'(cfg_index))
        ptr_pkg::CFG_DIMENSIONS: dims_cfg_r <= cfg_data[10:0];
        ptr_pkg::CFG_KEEP_COUNT: keep_cfg_r <= cfg_data[4:0];
        ptr_pkg::CFG_TRUNC_MODE: trunc_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row memories and fill counts; contents are defined by the first row.
  logic [ROW_W-1:0] hi_mem   [MAX_DIM];
  logic [ROW_W-1:0] lo_mem   [MAX_DIM];
  logic [KW-1:0]    fill_mem [MAX_DIM];

  logic [CNT_W-1:0] cnt_r;
  logic             first_row_r;

  logic [31:0]      val_r;
  logic             first_r;
  logic [DIM_W-1:0] d_r;
  logic             last_r;
  logic [KW-1:0]    k_r;
  logic [ROW_W-1:0] hi_rd_r, lo_rd_r;
  logic [KW-1:0]    fill_rd_r;

  // Dimension selection and effective K for the incoming transaction.
  logic [31:0]      dims32, kc32;
  logic [CNT_W-1:0] dims_eff, c_sel;
  logic [CNT_W:0]   c_plus;
  logic             last_c;
  logic [DIM_W-1:0] d_c;
  logic [KW-1:0]    k_c;

  always_comb begin
    dims32 = {21'd0, dims_cfg_r};
    if (dims32 == 32'd0) dims32 = 32'd1;
    if (dims32 > MAX_DIM) dims32 = MAX_DIM;
    dims_eff = dims32[CNT_W-1:0];
    c_sel = in_item.start_req ? '0 : cnt_r;
    if (c_sel >= dims_eff) c_sel = '0;
    c_plus = {1'b0, c_sel} + 1'b1;
    last_c = (c_plus >= {1'b0, dims_eff});
    d_c    = DIM_W'(c_sel);
    kc32 = 32'd1;
    if (trunc_r) begin
      kc32 = {27'd0, keep_cfg_r};
      if (kc32 < 32'd1) kc32 = 32'd1;
      if (kc32 > MAX_KEEP) kc32 = MAX_KEEP;
    end
    k_c = kc32[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      first_row_r <= 1'b1;
    end else if (cmd.accept) begin
      cnt_r       <= last_c ? '0 : c_plus[CNT_W-1:0];
      first_row_r <= last_c ? 1'b0 : (in_item.start_req | first_row_r);
    end
  end

  // Latch the transaction and read the dimension's rows.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r     <= in_item.value;
      first_r   <= in_item.start_req | first_row_r;
      d_r       <= d_c;
      last_r    <= last_c;
      k_r       <= k_c;
      hi_rd_r   <= hi_mem[d_c];
      lo_rd_r   <= lo_mem[d_c];
      fill_rd_r <= fill_mem[d_c];
    end
  end

  // Sorted insert: every entry compares against the new value in parallel.
  logic [31:0]      e_hi [MAX_KEEP];
  logic [31:0]      e_lo [MAX_KEEP];
  logic [31:0]      nw_hi [MAX_KEEP];
  logic [31:0]      nw_lo [MAX_KEEP];
  logic [MAX_KEEP-1:0] keep_hi, keep_lo;
  logic [31:0]      n32, m32, nn32, kv, tail_hi, tail_lo, up_c, lo_c;
  logic             is_num, grow, ins_hi, ins_lo;
  logic [ROW_W-1:0] hi_wr, lo_wr;

  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      e_hi[j] = hi_rd_r[j*32 +: 32];
      e_lo[j] = lo_rd_r[j*32 +: 32];
    end
    n32 = {{(32-KW){1'b0}}, fill_rd_r};
    if (first_r) begin
      e_hi[0] = ptr_pkg::F_LOWEST;
      e_lo[0] = ptr_pkg::F_MAX;
      n32     = 32'd1;
    end
    if (n32 > MAX_KEEP) n32 = MAX_KEEP;
    if (n32 > {{(32-KW){1'b0}}, k_r}) n32 = {{(32-KW){1'b0}}, k_r};

    is_num = ((val_r & 32'h7FFF_FFFF) <= ptr_pkg::F_INF);
    kv     = ptr_pkg::order_key(val_r);
    grow   = (n32 < {{(32-KW){1'b0}}, k_r});
    m32    = grow ? n32 : n32 - 32'd1;

    tail_hi = '0;
    tail_lo = '0;
    for (int j = 0; j < MAX_KEEP; j++) begin
      if (j == n32 - 32'd1) begin
        tail_hi = e_hi[j];
        tail_lo = e_lo[j];
      end
    end
    ins_hi = is_num && (grow || (n32 > 0 && kv > ptr_pkg::order_key(tail_hi)));
    ins_lo = is_num && (grow || (n32 > 0 && kv < ptr_pkg::order_key(tail_lo)));

    for (int j = 0; j < MAX_KEEP; j++) begin
      keep_hi[j] = (j < m32) && (ptr_pkg::order_key(e_hi[j]) >= kv);
      keep_lo[j] = (j < m32) && (ptr_pkg::order_key(e_lo[j]) <= kv);
    end
    for (int j = 0; j < MAX_KEEP; j++) begin
      nw_hi[j] = e_hi[j];
      nw_lo[j] = e_lo[j];
      if (ins_hi && !keep_hi[j])
        nw_hi[j] = (j == 0 || keep_hi[(j == 0) ? 0 : j-1]) ? val_r : e_hi[(j == 0) ? 0 : j-1];
      if (ins_lo && !keep_lo[j])
        nw_lo[j] = (j == 0 || keep_lo[(j == 0) ? 0 : j-1]) ? val_r : e_lo[(j == 0) ? 0 : j-1];
    end

    nn32 = n32 + ((is_num && grow) ? 32'd1 : 32'd0);
    up_c = '0;
    lo_c = '0;
    for (int j = 0; j < MAX_KEEP; j++) begin
      hi_wr[j*32 +: 32] = nw_hi[j];
      lo_wr[j*32 +: 32] = nw_lo[j];
      if (j == nn32 - 32'd1) begin
        up_c = nw_hi[j];
        lo_c = nw_lo[j];
      end
    end
  end

  // Write back the row and load the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_mem[d_r]          <= hi_wr;
      lo_mem[d_r]          <= lo_wr;
      fill_mem[d_r]        <= nn32[KW-1:0];
      out_item.dim_index   <= 10'(d_r);
      out_item.upper_bits  <= up_c;
      out_item.lower_bits  <= lo_c;
      out_item.row_end     <= last_r;
    end
  end

endmodule

`default_nettype wire

// ===== tb/per_dimension_trimmed_range_unit_tb.sv =====
// Testbench for the per-dimension trimmed range unit: directed table, then random phases.
// Depends on ptr_pkg, ptr_stream_if and per_dimension_trimmed_range_unit from src.
`timescale 1ns / 100ps

module per_dimension_trimmed_range_unit_tb;

  localparam int unsigned DIM_N     = 1024;
  localparam int unsigned KEEP_N    = 16;
  localparam int unsigned CYCLE_CAP = 1000000;
  localparam int unsigned HOLD_LEN  = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ptr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_data;

  ptr_stream_if #(.T(ptr_pkg::in_item_t))  in_if ();
  ptr_stream_if #(.T(ptr_pkg::out_item_t)) out_if ();

  per_dimension_trimmed_range_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Directed row: element, start flag and, where obvious, the bounds to expect.
  typedef struct {
    logic [31:0] value;
    bit          start;
    bit          fixed;
    logic [31:0] upper;
    logic [31:0] lower;
  } dir_row_t;

  typedef struct {
    bit                 fixed;
    ptr_pkg::out_item_t item;
  } pending_t;

  // Shadow copy of the block's configuration and kept-value store.
  logic [10:0] dims_reg;
  logic [4:0]  keep_reg;
  logic        trunc_reg;
  logic [31:0] top_vals [0:DIM_N-1][0:KEEP_N-1];
  logic [31:0] bot_vals [0:DIM_N-1][0:KEEP_N-1];
  int unsigned fill_cnt [0:DIM_N-1];
  int unsigned dim_pos;
  bit          fresh_row;

  ptr_pkg::out_item_t bounds_q [$];
  pending_t  fixed_q [$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned cycles;
  bit          hold_req;
  bit          no_idle;

  // Clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Float bits to an unsigned key that sorts in float order; both zeros equal.
  function automatic logic [31:0] float_rank(input logic [31:0] b);
    logic [31:0] z;
    z = (b[30:0] == 31'd0) ? 32'd0 : b;
    return z[31] ? ~z : (z | 32'h8000_0000);
  endfunction

  // Sorted insert into one row; the tail entry past cnt is pushed out.
  task automatic place_value(input bit high, input int unsigned d, input int unsigned cnt,
                             input logic [31:0] v);
    int unsigned pos;
    logic [31:0] kv;
    logic [31:0] ke;
    bit ahead;
    kv = float_rank(v);
    pos = 0;
    ahead = 0;
    while (pos < cnt && !ahead) begin
      ke = float_rank(high ? top_vals[d][pos] : bot_vals[d][pos]);
      ahead = high ? (kv > ke) : (kv < ke);
      if (!ahead) pos++;
    end
    for (int i = cnt; i > pos; i--) begin
      if (high) top_vals[d][i] = top_vals[d][i-1];
      else bot_vals[d][i] = bot_vals[d][i-1];
    end
    if (high) top_vals[d][pos] = v;
    else bot_vals[d][pos] = v;
  endtask

  // Works out the bounds reported for one accepted element.
  task automatic track_bounds(input logic [31:0] v, input bit s,
                              output ptr_pkg::out_item_t r);
    int unsigned dims;
    int unsigned k;
    int unsigned d;
    int unsigned n;
    bit grow;
    bit last;
    logic [31:0] kv;
    dims = (dims_reg == 0) ? 1 : ((dims_reg > DIM_N) ? DIM_N : dims_reg);
    k = 1;
    if (trunc_reg) k = (keep_reg < 1) ? 1 : ((keep_reg > KEEP_N) ? KEEP_N : keep_reg);
    if (s) begin
      dim_pos = 0;
      fresh_row = 1;
    end
    if (dim_pos >= dims) dim_pos = 0;
    d = dim_pos;
    if (fresh_row) begin
      top_vals[d][0] = ptr_pkg::F_LOWEST;
      bot_vals[d][0] = ptr_pkg::F_MAX;
      fill_cnt[d] = 1;
    end
    n = fill_cnt[d];
    if (n > KEEP_N) n = KEEP_N;
    if (n > k) n = k;
    // NaN elements are not inserted.
    if (v[30:0] <= 31'h7F80_0000) begin
      kv = float_rank(v);
      grow = (n < k);
      if (grow || (n > 0 && kv > float_rank(top_vals[d][n-1])))
        place_value(1'b1, d, grow ? n : n - 1, v);
      if (grow || (n > 0 && kv < float_rank(bot_vals[d][n-1])))
        place_value(1'b0, d, grow ? n : n - 1, v);
      if (grow) n++;
    end
    fill_cnt[d] = n;
    last = (d + 1 >= dims);
    r.dim_index  = d[9:0];
    r.upper_bits = (n > 0) ? top_vals[d][n-1] : 32'd0;
    r.lower_bits = (n > 0) ? bot_vals[d][n-1] : 32'd0;
    r.row_end    = last;
    if (last) begin
      dim_pos = 0;
      fresh_row = 0;
    end else begin
      dim_pos = d + 1;
    end
  endtask

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    ptr_pkg::out_item_t r;
    pending_t p;
    if (rst_n && in_if.valid && in_if.ready) begin
      track_bounds(in_if.data.value, in_if.data.start_req, r);
      p = fixed_q.pop_front();
      bounds_q.push_back(p.fixed ? p.item : r);
    end
  end

  // Check every accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    ptr_pkg::out_item_t e;
    ptr_pkg::out_item_t a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.data;
      results_seen++;
      if (bounds_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
      end else begin
        e = bounds_q.pop_front();
        if (a.dim_index !== e.dim_index) begin
          errors++;
          $display("%0t: dim_index expected %0d actual %0d", $time, e.dim_index, a.dim_index);
        end
        if (a.upper_bits !== e.upper_bits) begin
          errors++;
          $display("%0t: upper_bits expected %h actual %h", $time, e.upper_bits, a.upper_bits);
        end
        if (a.lower_bits !== e.lower_bits) begin
          errors++;
          $display("%0t: lower_bits expected %h actual %h", $time, e.lower_bits, a.lower_bits);
        end
        if (a.row_end !== e.row_end) begin
          errors++;
          $display("%0t: row_end expected %b actual %b", $time, e.row_end, a.row_end);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom % 100;
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Drives one element and waits for its acceptance; valid stays up between
  // back-to-back transactions.
  task automatic send_elem(input logic [31:0] v, input bit s, input bit fixed,
                           input ptr_pkg::out_item_t e);
    int unsigned gap;
    pending_t p;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.fixed = fixed;
    p.item = e;
    fixed_q.push_back(p);
    in_if.valid <= 1'b1;
    in_if.data  <= '{value: v, start_req: s};
    do @(posedge clk); while (!in_if.ready);
  endtask

  // The extra edge lets the predictor record the last accepted element first.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input ptr_pkg::cfg_idx_t idx,
                           input logic [ptr_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptr_pkg::CFG_DIMENSIONS: dims_reg  = val[10:0];
      ptr_pkg::CFG_KEEP_COUNT: keep_reg  = val[4:0];
      ptr_pkg::CFG_TRUNC_MODE: trunc_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random element: mostly clustered magnitudes so ordering matters.
  function automatic logic [31:0] rand_float();
    case ($urandom % 10)
      0, 1, 2, 3, 4, 5: return {1'($urandom), 8'($urandom_range(120, 135)), 23'($urandom)};
      6:       return $urandom;
      7: begin
        case ($urandom % 4)
          0:       return ptr_pkg::F_MAX;
          1:       return ptr_pkg::F_LOWEST;
          2:       return ptr_pkg::F_INF;
          default: return 32'hFF80_0000;
        endcase
      end
      8:       return {1'($urandom), 31'd0};
      default: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
    endcase
  endfunction

  // One phase of random elements; the first one starts a new data set if asked.
  task automatic run_phase(input int unsigned count, input bit open_set,
                           input int unsigned pause_at);
    ptr_pkg::out_item_t none;
    none = '0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == pause_at) wait_idle();
      send_elem(rand_float(), (i == 0 && open_set) || ($urandom % 60 == 0), 1'b0, none);
    end
    wait_idle();
  endtask

  // Directed elements under the reset configuration: one dimension, classic.
  dir_row_t dir_rows [] = '{
    '{32'h3F80_0000, 1, 1, 32'h3F80_0000, 32'h3F80_0000},
    '{32'h7FC0_0000, 0, 1, 32'h3F80_0000, 32'h3F80_0000},
    '{32'h7F80_0000, 0, 1, 32'h7F80_0000, 32'h3F80_0000},
    '{32'hFF80_0000, 0, 1, 32'h7F80_0000, 32'hFF80_0000},
    '{32'h8000_0000, 1, 1, 32'h8000_0000, 32'h8000_0000},
    '{32'h0000_0000, 0, 0, 32'h0, 32'h0},
    '{32'h7F7F_FFFF, 1, 1, 32'h7F7F_FFFF, 32'h7F7F_FFFF},
    '{32'hFF7F_FFFF, 1, 1, 32'hFF7F_FFFF, 32'hFF7F_FFFF},
    '{32'hFFFF_FFFF, 1, 1, 32'hFF7F_FFFF, 32'h7F7F_FFFF},
    '{32'h0000_0001, 0, 0, 32'h0, 32'h0},
    '{32'h8000_0001, 0, 0, 32'h0, 32'h0},
    '{32'h7F80_0001, 0, 0, 32'h0, 32'h0},
    '{32'hFF80_0001, 0, 0, 32'h0, 32'h0},
    '{32'hC000_0000, 1, 0, 32'h0, 32'h0},
    '{32'h4000_0000, 0, 0, 32'h0, 32'h0},
    '{32'h0000_0000, 0, 0, 32'h0, 32'h0},
    '{32'h8000_0000, 0, 0, 32'h0, 32'h0},
    '{32'h5555_5555, 0, 0, 32'h0, 32'h0},
    '{32'hAAAA_AAAA, 0, 0, 32'h0, 32'h0}
  };

  // Main sequence.
  initial begin
    ptr_pkg::out_item_t e;
    errors = 0;
    results_seen = 0;
    cycles = 0;
    hold_req = 0;
    no_idle = 0;
    dims_reg = 11'd1;
    keep_reg = 5'd0;
    trunc_reg = 1'b0;
    dim_pos = 0;
    fresh_row = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ptr_pkg::CFG_DIMENSIONS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      e.dim_index  = 10'd0;
      e.upper_bits = dir_rows[i].upper;
      e.lower_bits = dir_rows[i].lower;
      e.row_end    = 1'b1;
      send_elem(dir_rows[i].value, dir_rows[i].start, dir_rows[i].fixed, e);
    end
    wait_idle();

    // Classic min/max over four dimensions.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd4);
    run_phase(150, 1, 0);
    // Switch to trimming mid data set: rows grow toward three entries.
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd3);
    write_reg(ptr_pkg::CFG_TRUNC_MODE, 11'd1);
    run_phase(100, 0, 0);
    // Lower the trim depth mid data set: rows are cut back.
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd1);
    run_phase(60, 0, 0);
    // Zero dimensions and zero trim depth both act as one.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd0);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd0);
    run_phase(80, 1, 0);
    // Deepest trim, with a long result hold-off that backs up the input.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd7);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd16);
    hold_req = 1;
    run_phase(250, 1, 0);
    // Oversized dimension count and trim depth saturate.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd2047);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd31);
    run_phase(40, 1, 0);
    // Mid-size trim; the sender drains the block partway through.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd3);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd5);
    run_phase(300, 1, 150);
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd1024);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd2);
    write_reg(ptr_pkg::CFG_TRUNC_MODE, 11'd0);
    run_phase(40, 1, 0);
    // Back-to-back stretch with no idling on either side.
    write_reg(ptr_pkg::CFG_DIMENSIONS, 11'd2);
    write_reg(ptr_pkg::CFG_KEEP_COUNT, 11'd16);
    no_idle = 1;
    run_phase(230, 1, 0);
    no_idle = 0;

    repeat (20) @(posedge clk);
    $display("Checked %0d results over classic and trimmed modes, dimension counts 0 to 2047,",
             results_seen);
    $display("trim depths 0 to 31, NaN, infinities, signed zeros and mid-set setting changes.");
    if (errors == 0 && bounds_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
